FILE: src/letterbox_area_calculator_core_macros.svh
// ----------------------------------------------------------------------------
// Letterbox area calculator assertion macros
// Shared concurrent assertion helpers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LETTERBOX_AREA_CALCULATOR_CORE_MACROS_SVH
`define LETTERBOX_AREA_CALCULATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LBX_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbx assertion failed");
`define LBX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbx assertion failed");
`else
`define LBX_ASSERT_IMPL(lbl, ante, cons)
`define LBX_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/lbx_pkg.sv
// ----------------------------------------------------------------------------
// Letterbox area calculator package
// Widths and stage transfer types shared by the pipeline modules.
// ----------------------------------------------------------------------------
package lbx_pkg;

    localparam int COORD_W = 13;
    localparam int RATIO_W = 16;
    localparam int POS_W   = COORD_W + 1;
    localparam int P1_W    = COORD_W + RATIO_W;
    localparam int AB_W    = P1_W + RATIO_W;
    localparam int CR_W    = AB_W + COORD_W;
    localparam int QB      = COORD_W;

    typedef struct packed {
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        logic [COORD_W-1:0] tw;
        logic [COORD_W-1:0] th;
    } tgt_t;

    typedef struct packed {
        tgt_t            tgt;
        logic            wide;
        logic            fit;
        logic [CR_W-1:0] num;
        logic [AB_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        tgt_t            tgt;
        logic            wide;
        logic            fit;
        logic [QB-1:0]   q;
    } div_res_t;

endpackage

FILE: src/lbx_mul.sv
// ----------------------------------------------------------------------------
// Letterbox aspect product pipeline
// Four stages: partial products, A and B, cross products, compare and select.
// ----------------------------------------------------------------------------
module lbx_mul
    import lbx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  tgt_t               tgt,
    input  logic [COORD_W-1:0] frame_w,
    input  logic [COORD_W-1:0] frame_h,
    input  logic [RATIO_W-1:0] par_num,
    input  logic [RATIO_W-1:0] par_den,
    input  logic [RATIO_W-1:0] dar_num,
    input  logic [RATIO_W-1:0] dar_den,
    output logic               req_valid,
    output div_req_t           req
);

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    tgt_t               t1_reg, t2_reg, t3_reg;
    logic [P1_W-1:0]    pa_reg, pb_reg;
    logic [RATIO_W-1:0] dd_reg, dn_reg;
    logic [AB_W-1:0]    a2_reg, b2_reg, a3_reg, b3_reg;
    logic [CR_W-1:0]    lhs_reg, rhs_reg;
    div_req_t           req_reg, req_next;
    logic               wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg  <= tgt;
            pa_reg  <= P1_W'(frame_w) * P1_W'(par_num);
            pb_reg  <= P1_W'(frame_h) * P1_W'(par_den);
            dd_reg  <= dar_den;
            dn_reg  <= dar_num;
            t2_reg  <= t1_reg;
            a2_reg  <= AB_W'(pa_reg) * AB_W'(dd_reg);
            b2_reg  <= AB_W'(pb_reg) * AB_W'(dn_reg);
            t3_reg  <= t2_reg;
            a3_reg  <= a2_reg;
            b3_reg  <= b2_reg;
            lhs_reg <= CR_W'(a2_reg) * CR_W'(t2_reg.th);
            rhs_reg <= CR_W'(b2_reg) * CR_W'(t2_reg.tw);
            req_reg <= req_next;
        end
    end

    // wider source keeps target width and divides tw*B by A
    always_comb
    begin
        wide          = lhs_reg > rhs_reg;
        req_next.tgt  = t3_reg;
        req_next.wide = wide;
        req_next.fit  = (a3_reg != '0) && (b3_reg != '0) && (lhs_reg != rhs_reg);
        req_next.num  = wide ? rhs_reg : lhs_reg;
        req_next.den  = wide ? a3_reg : b3_reg;
    end

    assign req_valid = v4_reg;
    assign req       = req_reg;

endmodule

FILE: src/lbx_div.sv
// ----------------------------------------------------------------------------
// Letterbox pipelined divider
// Restoring division, one quotient bit per stage, QB stages.
// ----------------------------------------------------------------------------
`include "letterbox_area_calculator_core_macros.svh"
module lbx_div
    import lbx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     req_valid,
    input  div_req_t req,
    output logic     res_valid,
    output div_res_t res
);

    localparam int LAST = QB - 1;

    // entry k holds the state after quotient bit QB-1-k is resolved
    logic            v_reg   [QB];
    tgt_t            t_reg   [QB];
    logic            w_reg   [QB];
    logic            f_reg   [QB];
    logic [CR_W-1:0] r_reg   [QB];
    logic [AB_W-1:0] d_reg   [QB];
    logic [QB-1:0]   q_reg   [QB];
    logic [CR_W-1:0] r_next  [QB];
    logic [QB-1:0]   q_next  [QB];
    logic [CR_W-1:0] sh;
    logic            ge;

    always_comb
    begin
        sh              = CR_W'(req.den) << LAST;
        ge              = req.num >= sh;
        r_next[0]       = ge ? (req.num - sh) : req.num;
        q_next[0]       = '0;
        q_next[0][LAST] = ge;
        for (int k = 1; k < QB; k++)
        begin
            sh                  = CR_W'(d_reg[k-1]) << (LAST - k);
            ge                  = r_reg[k-1] >= sh;
            r_next[k]           = ge ? (r_reg[k-1] - sh) : r_reg[k-1];
            q_next[k]           = q_reg[k-1];
            q_next[k][LAST - k] = ge;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QB; k++)
                v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= req_valid;
            for (int k = 1; k < QB; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0] <= req.tgt;
            w_reg[0] <= req.wide;
            f_reg[0] <= req.fit;
            d_reg[0] <= req.den;
            for (int k = 1; k < QB; k++)
            begin
                t_reg[k] <= t_reg[k-1];
                w_reg[k] <= w_reg[k-1];
                f_reg[k] <= f_reg[k-1];
                d_reg[k] <= d_reg[k-1];
            end
            for (int k = 0; k < QB; k++)
            begin
                r_reg[k] <= r_next[k];
                q_reg[k] <= q_next[k];
            end
        end
    end

    assign res_valid = v_reg[LAST];
    assign res.tgt   = t_reg[LAST];
    assign res.wide  = w_reg[LAST];
    assign res.fit   = f_reg[LAST];
    assign res.q     = q_reg[LAST];

    // scaled side must fall inside the target
    `LBX_ASSERT_IMPL(a_q_below_th, v_reg[LAST] && f_reg[LAST] && w_reg[LAST], q_reg[LAST] < t_reg[LAST].th)
    `LBX_ASSERT_IMPL(a_q_below_tw, v_reg[LAST] && f_reg[LAST] && !w_reg[LAST], q_reg[LAST] < t_reg[LAST].tw)
    `LBX_ASSERT_IMPL(a_rem_small, v_reg[LAST] && f_reg[LAST], r_reg[LAST] < CR_W'(d_reg[LAST]))

endmodule

FILE: src/lbx_place.sv
// ----------------------------------------------------------------------------
// Letterbox placement stage
// Centers the scaled side, forms the bars and holds the output register.
// ----------------------------------------------------------------------------
module lbx_place
    import lbx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               res_valid,
    input  div_res_t           res,
    output logic               out_valid,
    output logic [POS_W-1:0]   video_x,
    output logic [POS_W-1:0]   video_y,
    output logic [COORD_W-1:0] video_w,
    output logic [COORD_W-1:0] video_h,
    output logic [POS_W-1:0]   bar1_x,
    output logic [POS_W-1:0]   bar1_y,
    output logic [COORD_W-1:0] bar1_w,
    output logic [COORD_W-1:0] bar1_h,
    output logic [POS_W-1:0]   bar2_x,
    output logic [POS_W-1:0]   bar2_y,
    output logic [COORD_W-1:0] bar2_w,
    output logic [COORD_W-1:0] bar2_h
);

    logic               v_reg;
    logic [POS_W-1:0]   vx_reg, vy_reg, b1x_reg, b1y_reg, b2x_reg, b2y_reg;
    logic [COORD_W-1:0] vw_reg, vh_reg, b1w_reg, b1h_reg, b2w_reg, b2h_reg;
    logic [POS_W-1:0]   vx_next, vy_next, b1x_next, b1y_next, b2x_next, b2y_next;
    logic [COORD_W-1:0] vw_next, vh_next, b1w_next, b1h_next, b2w_next, b2h_next;
    logic [COORD_W-1:0] slack, half;
    logic [POS_W-1:0]   pos;

    always_comb
    begin
        slack    = (res.wide ? res.tgt.th : res.tgt.tw) - res.q;
        half     = slack >> 1;
        pos      = (res.wide ? {1'b0, res.tgt.ty} : {1'b0, res.tgt.tx}) + {1'b0, half};
        vx_next  = {1'b0, res.tgt.tx};
        vy_next  = {1'b0, res.tgt.ty};
        vw_next  = res.tgt.tw;
        vh_next  = res.tgt.th;
        b1x_next = '0;
        b1y_next = '0;
        b1w_next = '0;
        b1h_next = '0;
        b2x_next = '0;
        b2y_next = '0;
        b2w_next = '0;
        b2h_next = '0;
        if (res.fit)
        begin
            b1x_next = {1'b0, res.tgt.tx};
            b1y_next = {1'b0, res.tgt.ty};
            if (res.wide)
            begin
                vy_next  = pos;
                vh_next  = res.q;
                b1w_next = res.tgt.tw;
                b1h_next = half;
                b2x_next = {1'b0, res.tgt.tx};
                b2y_next = pos + {1'b0, res.q};
                b2w_next = res.tgt.tw;
                b2h_next = slack - half;
            end
            else
            begin
                vx_next  = pos;
                vw_next  = res.q;
                b1w_next = half;
                b1h_next = res.tgt.th;
                b2x_next = pos + {1'b0, res.q};
                b2y_next = {1'b0, res.tgt.ty};
                b2w_next = slack - half;
                b2h_next = res.tgt.th;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg  <= vx_next;
            vy_reg  <= vy_next;
            vw_reg  <= vw_next;
            vh_reg  <= vh_next;
            b1x_reg <= b1x_next;
            b1y_reg <= b1y_next;
            b1w_reg <= b1w_next;
            b1h_reg <= b1h_next;
            b2x_reg <= b2x_next;
            b2y_reg <= b2y_next;
            b2w_reg <= b2w_next;
            b2h_reg <= b2h_next;
        end
    end

    assign out_valid = v_reg;
    assign video_x   = vx_reg;
    assign video_y   = vy_reg;
    assign video_w   = vw_reg;
    assign video_h   = vh_reg;
    assign bar1_x    = b1x_reg;
    assign bar1_y    = b1y_reg;
    assign bar1_w    = b1w_reg;
    assign bar1_h    = b1h_reg;
    assign bar2_x    = b2x_reg;
    assign bar2_y    = b2y_reg;
    assign bar2_w    = b2w_reg;
    assign bar2_h    = b2h_reg;

endmodule

FILE: src/letterbox_area_calculator_core.sv
// ----------------------------------------------------------------------------
// Letterbox area calculator core
// Fits an aspect-corrected frame centered in a target rectangle.
// ----------------------------------------------------------------------------
// One transfer in, one transfer out, a new item every cycle while out_stall
// does not hold the pipeline. The path runs through four multiply/compare
// stages, a 13-stage restoring divider that resolves one quotient bit per
// stage, and the placement stage that is also the output register. The whole
// pipeline advances together; it freezes only while the output holds a result
// and out_stall is high, so nothing is dropped or repeated.
module letterbox_area_calculator_core
    import lbx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [COORD_W-1:0] target_x,
    input  logic [COORD_W-1:0] target_y,
    input  logic [COORD_W-1:0] target_w,
    input  logic [COORD_W-1:0] target_h,
    input  logic [COORD_W-1:0] frame_w,
    input  logic [COORD_W-1:0] frame_h,
    input  logic [RATIO_W-1:0] par_num,
    input  logic [RATIO_W-1:0] par_den,
    input  logic [RATIO_W-1:0] dar_num,
    input  logic [RATIO_W-1:0] dar_den,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [POS_W-1:0]   video_x,
    output logic [POS_W-1:0]   video_y,
    output logic [COORD_W-1:0] video_w,
    output logic [COORD_W-1:0] video_h,
    output logic [POS_W-1:0]   bar1_x,
    output logic [POS_W-1:0]   bar1_y,
    output logic [COORD_W-1:0] bar1_w,
    output logic [COORD_W-1:0] bar1_h,
    output logic [POS_W-1:0]   bar2_x,
    output logic [POS_W-1:0]   bar2_y,
    output logic [COORD_W-1:0] bar2_w,
    output logic [COORD_W-1:0] bar2_h
);

    logic     en;
    tgt_t     tgt;
    logic     req_valid, res_valid;
    div_req_t req;
    div_res_t res;

    // pipeline moves unless a finished result is held back
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    assign tgt.tx = target_x;
    assign tgt.ty = target_y;
    assign tgt.tw = target_w;
    assign tgt.th = target_h;

    lbx_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .tgt       (tgt),
        .frame_w   (frame_w),
        .frame_h   (frame_h),
        .par_num   (par_num),
        .par_den   (par_den),
        .dar_num   (dar_num),
        .dar_den   (dar_den),
        .req_valid (req_valid),
        .req       (req)
    );

    lbx_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .req_valid (req_valid),
        .req       (req),
        .res_valid (res_valid),
        .res       (res)
    );

    lbx_place u_place (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .res_valid (res_valid),
        .res       (res),
        .out_valid (out_valid),
        .video_x   (video_x),
        .video_y   (video_y),
        .video_w   (video_w),
        .video_h   (video_h),
        .bar1_x    (bar1_x),
        .bar1_y    (bar1_y),
        .bar1_w    (bar1_w),
        .bar1_h    (bar1_h),
        .bar2_x    (bar2_x),
        .bar2_y    (bar2_y),
        .bar2_w    (bar2_w),
        .bar2_h    (bar2_h)
    );

endmodule

FILE: tb/tb_letterbox_area_calculator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Letterbox area calculator core testbench
// Random and corner-case rectangles and aspect fractions are driven with
// bursty input and a patterned output stall. Each fitted result is compared
// field by field against an in-bench fit computed at full precision.
// ----------------------------------------------------------------------------
module tb_letterbox_area_calculator_core;
    import lbx_pkg::*;

    localparam int N_RANDOM    = 1750;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    // One request: target rectangle, frame size and both aspect fractions.
    typedef struct packed {
        logic [COORD_W-1:0] tx, ty, tw, th, fw, fh;
        logic [RATIO_W-1:0] pn, pd, dn, dd;
    } fit_req_t;

    // One fitted layout: video rectangle and the two bars.
    typedef struct packed {
        logic [POS_W-1:0]   vx, vy;
        logic [COORD_W-1:0] vw, vh;
        logic [POS_W-1:0]   b1x, b1y;
        logic [COORD_W-1:0] b1w, b1h;
        logic [POS_W-1:0]   b2x, b2y;
        logic [COORD_W-1:0] b2w, b2h;
    } layout_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    fit_req_t req = '0;
    layout_t  res;

    fit_req_t pending_reqs[$];
    layout_t  expected_layouts[$];
    int  mismatches = 0;
    int  cycle_count = 0;
    bit  stimulus_done = 1'b0;

    always #5 clk = ~clk;

    letterbox_area_calculator_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .target_x(req.tx), .target_y(req.ty), .target_w(req.tw), .target_h(req.th),
        .frame_w(req.fw), .frame_h(req.fh),
        .par_num(req.pn), .par_den(req.pd), .dar_num(req.dn), .dar_den(req.dd),
        .out_valid(out_valid), .out_stall(out_stall),
        .video_x(res.vx), .video_y(res.vy), .video_w(res.vw), .video_h(res.vh),
        .bar1_x(res.b1x), .bar1_y(res.b1y), .bar1_w(res.b1w), .bar1_h(res.b1h),
        .bar2_x(res.b2x), .bar2_y(res.b2y), .bar2_w(res.b2w), .bar2_h(res.b2h)
    );

    // Aspect fit. Products reach 13+16+16+13 = 58 bits, so 64-bit math is exact.
    function automatic layout_t fit_layout(input fit_req_t r);
        logic [63:0] a, b, lhs, rhs, vx, vy, vw, vh;
        layout_t o;
        a   = 64'(r.fw) * 64'(r.pn) * 64'(r.dd);
        b   = 64'(r.fh) * 64'(r.pd) * 64'(r.dn);
        lhs = a * 64'(r.th);
        rhs = b * 64'(r.tw);
        o   = '0;
        vx = 64'(r.tx); vy = 64'(r.ty); vw = 64'(r.tw); vh = 64'(r.th);
        if (a != 0 && b != 0 && lhs != rhs) begin
            if (lhs > rhs) begin
                // Wider source: full width, bars above and below.
                vh = (64'(r.tw) * b) / a;
                vy = 64'(r.ty) + (64'(r.th) - vh) / 64'd2;
                o.b1x = POS_W'(r.tx); o.b1y = POS_W'(r.ty); o.b1w = r.tw;
                o.b1h = COORD_W'(vy - 64'(r.ty));
                o.b2x = POS_W'(r.tx); o.b2y = POS_W'(vy + vh); o.b2w = r.tw;
                o.b2h = COORD_W'(64'(r.ty) + 64'(r.th) - (vy + vh));
            end
            else begin
                // Narrower source: full height, bars left and right.
                vw = (64'(r.th) * a) / b;
                vx = 64'(r.tx) + (64'(r.tw) - vw) / 64'd2;
                o.b1x = POS_W'(r.tx); o.b1y = POS_W'(r.ty);
                o.b1w = COORD_W'(vx - 64'(r.tx)); o.b1h = r.th;
                o.b2x = POS_W'(vx + vw); o.b2y = POS_W'(r.ty);
                o.b2w = COORD_W'(64'(r.tx) + 64'(r.tw) - (vx + vw)); o.b2h = r.th;
            end
        end
        o.vx = POS_W'(vx); o.vy = POS_W'(vy);
        o.vw = COORD_W'(vw); o.vh = COORD_W'(vh);
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    function automatic fit_req_t make_req(input int tx, ty, tw, th, fw, fh, pn, pd, dn, dd);
        fit_req_t r;
        r.tx = COORD_W'(tx); r.ty = COORD_W'(ty); r.tw = COORD_W'(tw);
        r.th = COORD_W'(th); r.fw = COORD_W'(fw); r.fh = COORD_W'(fh);
        r.pn = RATIO_W'(pn); r.pd = RATIO_W'(pd);
        r.dn = RATIO_W'(dn); r.dd = RATIO_W'(dd);
        return r;
    endfunction

    // Half realistic geometry with small ratios; a third fully random items.
    function automatic fit_req_t random_req();
        fit_req_t r;
        case ($urandom_range(0, 5))
            0, 1: begin
                r = make_req($urandom_range(0, 8191), $urandom_range(0, 8191),
                    $urandom_range(0, 8191), $urandom_range(0, 8191),
                    $urandom_range(0, 8191), $urandom_range(0, 8191),
                    $urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
            end
            2: begin
                // Near-equal ratios probe one-pixel slack.
                r = make_req($urandom_range(0, 8191), $urandom_range(0, 8191),
                    $urandom_range(1, 64), $urandom_range(1, 64),
                    $urandom_range(1, 64), $urandom_range(1, 64), 1, 1, 1, 1);
            end
            default: begin
                r = make_req($urandom_range(0, 4000), $urandom_range(0, 4000),
                    $urandom_range(1, 4000), $urandom_range(1, 4000),
                    $urandom_range(1, 4000), $urandom_range(1, 4000),
                    $urandom_range(1, 40), $urandom_range(1, 40),
                    $urandom_range(1, 20), $urandom_range(1, 20));
            end
        endcase
        return r;
    endfunction

    // Fill the request queue: directed corners first, then random.
    initial begin
        pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(8191, 8191, 8191, 8191, 8191, 8191,
            65535, 65535, 65535, 65535));
        pending_reqs.push_back(make_req(100, 50, 1920, 1080, 640, 480, 1, 1, 1, 1));
        pending_reqs.push_back(make_req(100, 50, 1280, 1024, 1920, 1080, 1, 1, 1, 1));
        pending_reqs.push_back(make_req(10, 20, 1920, 1080, 1920, 1080, 1, 1, 1, 1));
        pending_reqs.push_back(make_req(10, 20, 1920, 1080, 720, 576, 16, 15, 4, 3));
        pending_reqs.push_back(make_req(1, 1, 640, 480, 0, 480, 1, 1, 1, 1));
        pending_reqs.push_back(make_req(1, 1, 640, 480, 640, 480, 1, 0, 1, 1));
        pending_reqs.push_back(make_req(1, 1, 640, 480, 640, 480, 1, 1, 0, 1));
        pending_reqs.push_back(make_req(5, 5, 3, 2, 1, 1, 1, 1, 1, 1));
        pending_reqs.push_back(make_req(5, 5, 2, 3, 1, 1, 1, 1, 1, 1));
        pending_reqs.push_back(make_req(5, 5, 100, 0, 4, 3, 1, 1, 1, 1));
        pending_reqs.push_back(make_req(5, 5, 0, 100, 4, 3, 1, 1, 1, 1));
        pending_reqs.push_back(make_req(8191, 8191, 8191, 1, 1, 8191,
            65535, 1, 1, 65535));
        pending_reqs.push_back(make_req(8191, 8191, 1, 8191, 8191, 1,
            1, 65535, 65535, 1));
        pending_reqs.push_back(make_req(0, 8191, 8191, 8191, 8191, 1, 1, 1, 1, 1));
        pending_reqs.push_back(make_req(8191, 0, 8191, 8191, 1, 8191, 1, 1, 1, 1));
        for (int i = 0; i < N_RANDOM; i++)
            pending_reqs.push_back(random_req());
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: bursts of valid separated by random gaps; payload held while stalled.
    int burst_left = 0;
    int gap_left   = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                void'(pending_reqs.pop_front());
            end
            if (in_valid && in_stall) begin
                // hold the current transfer
            end
            else if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0) begin
                in_valid <= 1'b1;
                req      <= pending_reqs[0];
                expected_layouts.push_back(fit_layout(pending_reqs[0]));
                if (burst_left > 0)
                    burst_left--;
                else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end
            end
            else begin
                in_valid <= 1'b0;
                stimulus_done = 1'b1;
            end
        end
    end

    // Receiver stall: alternates stretches of random stalls and free flow.
    int stall_phase = 0;
    always @(posedge clk) begin
        stall_phase = (stall_phase + 1) % 200;
        if (stall_phase < 60)
            out_stall <= 1'b0;
        else if (stall_phase < 130)
            out_stall <= ($urandom_range(0, 3) == 0);
        else
            out_stall <= ($urandom_range(0, 1) == 0);
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge clk) begin
        layout_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_layouts.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end
            else begin
                want = expected_layouts.pop_front();
                if (res.vx  !== want.vx)
                    report_mismatch("video_x", int'(res.vx), int'(want.vx));
                if (res.vy  !== want.vy)
                    report_mismatch("video_y", int'(res.vy), int'(want.vy));
                if (res.vw  !== want.vw)
                    report_mismatch("video_w", int'(res.vw), int'(want.vw));
                if (res.vh  !== want.vh)
                    report_mismatch("video_h", int'(res.vh), int'(want.vh));
                if (res.b1x !== want.b1x)
                    report_mismatch("bar1_x", int'(res.b1x), int'(want.b1x));
                if (res.b1y !== want.b1y)
                    report_mismatch("bar1_y", int'(res.b1y), int'(want.b1y));
                if (res.b1w !== want.b1w)
                    report_mismatch("bar1_w", int'(res.b1w), int'(want.b1w));
                if (res.b1h !== want.b1h)
                    report_mismatch("bar1_h", int'(res.b1h), int'(want.b1h));
                if (res.b2x !== want.b2x)
                    report_mismatch("bar2_x", int'(res.b2x), int'(want.b2x));
                if (res.b2y !== want.b2y)
                    report_mismatch("bar2_y", int'(res.b2y), int'(want.b2y));
                if (res.b2w !== want.b2w)
                    report_mismatch("bar2_w", int'(res.b2w), int'(want.b2w));
                if (res.b2h !== want.b2h)
                    report_mismatch("bar2_h", int'(res.b2h), int'(want.b2h));
            end
        end
    end

    // End of run: drain, then allow the pipeline latency for stray results.
    initial begin
        wait (stimulus_done && expected_layouts.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_layouts.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule

FILE: letterbox_area_calculator_core.f
+incdir+src
src/lbx_pkg.sv
src/lbx_mul.sv
src/lbx_div.sv
src/lbx_place.sv
src/letterbox_area_calculator_core.sv
tb/tb_letterbox_area_calculator_core.sv
